// File: rtl/pfrx_pkg.sv
// Shared types and constants of the preamble frame receiver.
package pfrx_pkg;

  // Receive phases; codes above PH_CHECK are never entered.
  typedef enum logic [3:0] {
    PH_HUNT0 = 4'd0,
    PH_HUNT1 = 4'd1,
    PH_HUNT2 = 4'd2,
    PH_HUNT3 = 4'd3,
    PH_LEN   = 4'd4,
    PH_SRC   = 4'd5,
    PH_DST   = 4'd6,
    PH_DATA  = 4'd7,
    PH_CHECK = 4'd8
  } phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  // Input item modes.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Preamble bytes.
  localparam logic [7:0] PRE0 = 8'h01;
  localparam logic [7:0] PRE1 = 8'h02;
  localparam logic [7:0] PRE2 = 8'h03;
  localparam logic [7:0] PRE3 = 8'h04;

  // Reset value of the timeout register.
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

  // Frame state apart from the tick timer.
  typedef struct packed {
    phase_t     phase;
    logic [7:0] length;
    logic [7:0] source;
    logic [7:0] dest;
    logic [7:0] count;
    logic [7:0] xsum;
  } frame_state_t;

  // One result beat.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic [7:0] source_addr;
    logic [7:0] dest_addr;
    logic [7:0] computed_check;
    logic       last;
  } result_t;

endpackage

// File: rtl/pfrx_in_if.sv
// Input channel: one received byte or one time tick per beat.
interface pfrx_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

// File: rtl/pfrx_out_if.sv
// Result channel: payload bytes and frame end reports.
interface pfrx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] frame_length;
  logic [7:0] source_addr;
  logic [7:0] dest_addr;
  logic [7:0] computed_check;
  logic       last;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output frame_length, output source_addr, output dest_addr,
                  output computed_check, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input frame_length, input source_addr, input dest_addr,
                input computed_check, input last, output ready);
endinterface

// File: rtl/pfrx_cfg_if.sv
// Configuration write channel for the timeout register.
interface pfrx_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pfrx_step.sv
// Next-state and result logic for one accepted input beat.
module pfrx_step
  import pfrx_pkg::*;
#(
  parameter int TIMER_BITS = 32
) (
  input  frame_state_t          st,
  input  logic [TIMER_BITS-1:0] elapsed,
  input  logic [31:0]           timeout,
  input  logic                  mode,
  input  logic [7:0]            rx_byte,
  output frame_state_t          st_nxt,
  output logic [TIMER_BITS-1:0] elapsed_nxt,
  output logic                  res_valid,
  output result_t               res
);

  localparam int CMP_BITS = (TIMER_BITS > 32) ? TIMER_BITS : 32;

  logic [TIMER_BITS-1:0] elapsed_inc;
  logic                  timed_out;
  logic [7:0]            xsum_new;
  logic                  data_done;

  // Saturating tick count and the timeout compare on the incremented value.
  always_comb begin
    elapsed_inc = (elapsed != '1) ? elapsed + 1'b1 : elapsed;
    timed_out   = CMP_BITS'(elapsed_inc) > CMP_BITS'(timeout);
    xsum_new    = st.xsum ^ rx_byte;
    data_done   = ({1'b0, st.count} + 9'd1) >= {1'b0, st.length};
  end

  // One step of the receive sequence.
  always_comb begin
    st_nxt             = st;
    elapsed_nxt        = elapsed;
    res_valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.data_byte      = rx_byte;
    res.byte_index     = st.count;
    res.frame_length   = st.length;
    res.source_addr    = st.source;
    res.dest_addr      = st.dest;
    res.computed_check = xsum_new;
    res.last           = 1'b0;

    if (mode == MODE_TICK) begin
      // Ticks age an open frame and abandon it past the timeout.
      if (st.phase == PH_HUNT0 || st.phase > PH_CHECK) begin
        st_nxt.phase = PH_HUNT0;
      end else begin
        elapsed_nxt = elapsed_inc;
        if (timed_out) begin
          st_nxt.phase = PH_HUNT0;
        end
      end
    end else begin
      unique case (st.phase)
        PH_HUNT1: begin
          st_nxt.xsum  = xsum_new;
          st_nxt.phase = (rx_byte == PRE1) ? PH_HUNT2 : PH_HUNT0;
        end
        PH_HUNT2: begin
          st_nxt.xsum  = xsum_new;
          st_nxt.phase = (rx_byte == PRE2) ? PH_HUNT3 : PH_HUNT0;
        end
        PH_HUNT3: begin
          st_nxt.xsum  = xsum_new;
          st_nxt.phase = (rx_byte == PRE3) ? PH_LEN : PH_HUNT0;
        end
        PH_LEN: begin
          st_nxt.xsum   = xsum_new;
          st_nxt.length = rx_byte;
          st_nxt.phase  = PH_SRC;
        end
        PH_SRC: begin
          st_nxt.xsum   = xsum_new;
          st_nxt.source = rx_byte;
          st_nxt.phase  = PH_DST;
        end
        PH_DST: begin
          st_nxt.xsum  = xsum_new;
          st_nxt.dest  = rx_byte;
          st_nxt.count = 8'd0;
          st_nxt.phase = (st.length == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          st_nxt.xsum  = xsum_new;
          st_nxt.count = st.count + 8'd1;
          if (data_done) begin
            st_nxt.phase = PH_CHECK;
          end
          res_valid = 1'b1;
        end
        PH_CHECK: begin
          st_nxt.phase       = PH_HUNT0;
          res_valid          = 1'b1;
          res.kind           = (rx_byte == st.xsum) ? KIND_OK : KIND_BAD;
          res.byte_index     = 8'd0;
          res.computed_check = st.xsum;
          res.last           = 1'b1;
        end
        default: begin
          // Hunting the first preamble byte; unused codes behave the same.
          st_nxt.phase = PH_HUNT0;
          if (rx_byte == PRE0) begin
            elapsed_nxt  = '0;
            st_nxt.xsum  = rx_byte;
            st_nxt.phase = PH_HUNT1;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/preamble_frame_receiver_xor_check_top.sv
// Top level of the preamble frame receiver with XOR check.
//
// The input channel carries one beat per received line byte (mode 0) or per
// time tick (mode 1). The receiver hunts for the preamble 01 02 03 04, takes
// length, source and destination bytes, then emits one result beat per
// payload byte with its index, and a frame end beat (last set) that reports
// accepted or mismatch from the XOR of all frame bytes before the check byte.
// Preamble, header and tick beats give no result. Ticks age an open frame;
// past timeout_ticks the frame is dropped without a result.
// The configuration channel writes timeout_ticks and is always ready.
// A result appears on the output register in the cycle after its input
// beat is accepted. Throughput: one input beat per cycle, set by the single
// state update between the input handshake and the result register.
// When the result receiver stalls, the pending result is held and the input
// stalls only while that register is full and not being taken.
// Reset clears the output register, returns to the hunt and reloads the
// timeout with 1000000 ticks.
module preamble_frame_receiver_xor_check_top
  import pfrx_pkg::*;
#(
  parameter int TIMER_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pfrx_in_if.sink    in_bus,
  pfrx_out_if.source out_bus,
  pfrx_cfg_if.sink   cfg_bus
);

  frame_state_t          st_r;
  frame_state_t          st_nxt;
  logic [TIMER_BITS-1:0] elapsed_r;
  logic [TIMER_BITS-1:0] elapsed_nxt;
  logic [31:0]           timeout_r;
  logic                  out_valid_r;
  result_t               res_r;
  result_t               res;
  logic                  res_valid;
  logic                  in_acc;

  // Handshakes: input is taken while the result register is free or draining.
  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  // Per-beat state step.
  pfrx_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .st         (st_r),
    .elapsed    (elapsed_r),
    .timeout    (timeout_r),
    .mode       (in_bus.mode),
    .rx_byte    (in_bus.rx_byte),
    .st_nxt     (st_nxt),
    .elapsed_nxt(elapsed_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Frame state and timer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase  <= PH_HUNT0;
      st_r.length <= 8'd0;
      st_r.source <= 8'd0;
      st_r.dest   <= 8'd0;
      st_r.count  <= 8'd0;
      st_r.xsum   <= 8'd0;
      elapsed_r   <= '0;
    end else if (in_acc) begin
      st_r      <= st_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Timeout register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      timeout_r <= cfg_bus.data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_valid;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      res_r <= res;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.kind           = res_r.kind;
  assign out_bus.data_byte      = res_r.data_byte;
  assign out_bus.byte_index     = res_r.byte_index;
  assign out_bus.frame_length   = res_r.frame_length;
  assign out_bus.source_addr    = res_r.source_addr;
  assign out_bus.dest_addr      = res_r.dest_addr;
  assign out_bus.computed_check = res_r.computed_check;
  assign out_bus.last           = res_r.last;

  // The payload phase is only entered with a non-zero length.
  a_data_len : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_DATA |-> st_r.length != 8'd0)
    else $error("payload phase with zero length");

  // A check byte closes the frame with a frame end beat.
  a_check_end : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_bus.mode == MODE_BYTE && st_r.phase == PH_CHECK
    |=> st_r.phase == PH_HUNT0 && out_valid_r && res_r.last)
    else $error("check byte did not end the frame");

  // Ticks while hunting change nothing and give no result.
  a_tick_hunt : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_bus.mode == MODE_TICK && st_r.phase == PH_HUNT0
    |=> st_r.phase == PH_HUNT0 && !out_valid_r && $stable(elapsed_r))
    else $error("tick disturbed the hunt");

  // A payload beat never carries the frame end flag.
  a_data_kind : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_bus.mode == MODE_BYTE && st_r.phase == PH_DATA
    |=> out_valid_r && !res_r.last && res_r.kind == KIND_DATA)
    else $error("payload beat malformed");

endmodule

// File: sim/preamble_frame_receiver_xor_check_top_tb.sv
// Self-checking testbench for the preamble frame receiver with XOR check.
module preamble_frame_receiver_xor_check_top_tb;
  import pfrx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMER_BITS  = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LATENCY_PAD = 4;
  localparam int PHASE_ITEMS = 160;

  // One line event waiting to be sent: a byte or a tick.
  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } line_item_t;

  logic clk;
  logic rst_n;

  pfrx_in_if  in_ch ();
  pfrx_out_if out_ch ();
  pfrx_cfg_if cfg_ch ();

  preamble_frame_receiver_xor_check_top #(
    .TIMER_BITS(TIMER_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  line_item_t line_items[$];
  result_t    frame_reports[$];
  int         items_queued = 0;
  int         items_taken = 0;
  int         send_gap_pct;
  int         recv_stall_pct;
  int         cycle_count = 0;
  bit         failed = 1'b0;
  logic [31:0] cur_timeout;
  logic [31:0] timeout_plan[6];

  // Receiver state as the block should hold it.
  phase_t                ph;
  logic [7:0]            flen;
  logic [7:0]            fsrc;
  logic [7:0]            fdst;
  logic [7:0]            count;
  logic [7:0]            xsum;
  logic [TIMER_BITS-1:0] elapsed;
  logic [31:0]           timeout_q;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the receiver by one accepted beat and queue any result it gives.
  task automatic advance_receiver(input logic mode, input logic [7:0] b);
    result_t    r;
    logic [7:0] idx;
    if (mode == MODE_TICK) begin
      // Ticks only age an open frame; the timer saturates.
      if (ph != PH_HUNT0) begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        if (elapsed > timeout_q) ph = PH_HUNT0;
      end
      return;
    end
    case (ph)
      PH_HUNT0: begin
        if (b == PRE0) begin
          elapsed = '0;
          xsum = b;
          ph = PH_HUNT1;
        end
      end
      PH_HUNT1: begin
        xsum ^= b;
        ph = (b == PRE1) ? PH_HUNT2 : PH_HUNT0;
      end
      PH_HUNT2: begin
        xsum ^= b;
        ph = (b == PRE2) ? PH_HUNT3 : PH_HUNT0;
      end
      PH_HUNT3: begin
        xsum ^= b;
        ph = (b == PRE3) ? PH_LEN : PH_HUNT0;
      end
      PH_LEN: begin
        xsum ^= b;
        flen = b;
        ph = PH_SRC;
      end
      PH_SRC: begin
        xsum ^= b;
        fsrc = b;
        ph = PH_DST;
      end
      PH_DST: begin
        xsum ^= b;
        fdst = b;
        count = '0;
        ph = (flen == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        idx = count;
        xsum ^= b;
        count = count + 8'd1;
        if ({1'b0, idx} + 9'd1 >= {1'b0, flen}) ph = PH_CHECK;
        r = '{kind: KIND_DATA, data_byte: b, byte_index: idx, frame_length: flen,
              source_addr: fsrc, dest_addr: fdst, computed_check: xsum, last: 1'b0};
        frame_reports.push_back(r);
      end
      default: begin
        // Check byte: report the frame end and go back to the hunt.
        r = '{kind: (b == xsum) ? KIND_OK : KIND_BAD, data_byte: b, byte_index: 8'd0,
              frame_length: flen, source_addr: fsrc, dest_addr: fdst,
              computed_check: xsum, last: 1'b1};
        frame_reports.push_back(r);
        ph = PH_HUNT0;
      end
    endcase
  endtask

  task automatic field_check(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  task automatic push_item(input logic mode, input logic [7:0] b);
    line_items.push_back('{mode: mode, rx_byte: b});
    items_queued++;
  endtask

  // A complete frame, optionally with a bad check byte and ticks in between.
  task automatic push_frame(input int len, input logic [7:0] src, input logic [7:0] dst,
                            input bit corrupt, input int tick_pct);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    frame_bytes = {PRE0, PRE1, PRE2, PRE3, len[7:0], src, dst};
    repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
    sum = '0;
    foreach (frame_bytes[i]) sum ^= frame_bytes[i];
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(sum);
    foreach (frame_bytes[i]) begin
      if (i != 0 && $urandom_range(99) < tick_pct) begin
        push_item(MODE_TICK, 8'($urandom_range(255)));
      end
      push_item(MODE_BYTE, frame_bytes[i]);
    end
  endtask

  // Mostly well-formed frames, with broken preambles, stalled frames and noise.
  task automatic random_traffic(input int budget);
    int         first;
    int         pick;
    int         len;
    int         k;
    int         n;
    logic [7:0] b;
    logic [7:0] preamble[4];
    preamble = '{PRE0, PRE1, PRE2, PRE3};
    first = items_queued;
    while (items_queued - first < budget) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        k = $urandom_range(99);
        if (k < 4) len = $urandom_range(100, 255);
        else if (k < 14) len = 0;
        else len = $urandom_range(1, 12);
        push_frame(len, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   $urandom_range(3) == 0,
                   ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 4 : 20));
      end else if (pick < 74) begin
        // Preamble broken after a few good bytes; the bad byte is often 01.
        k = $urandom_range(0, 2);
        for (int i = 0; i <= k; i++) push_item(MODE_BYTE, preamble[i]);
        b = $urandom_range(1) ? PRE0 : 8'($urandom_range(255));
        if (b == preamble[k + 1]) b ^= 8'h80;
        push_item(MODE_BYTE, b);
      end else if (pick < 84) begin
        // Frame cut short, then a burst of ticks that may outlast the timeout.
        foreach (preamble[i]) push_item(MODE_BYTE, preamble[i]);
        repeat ($urandom_range(0, 4)) push_item(MODE_BYTE, 8'($urandom_range(255)));
        n = (cur_timeout < 40) ? int'(cur_timeout) + 1 : $urandom_range(1, 6);
        repeat (n) push_item(MODE_TICK, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(3) == 0) push_item(MODE_TICK, 8'($urandom_range(255)));
          else push_item(MODE_BYTE, 8'($urandom_range(1) ? $urandom_range(0, 5)
                                                          : $urandom_range(255)));
        end
      end
    end
  endtask

  task automatic write_timeout(input logic [31:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every beat has been sent and every result has come back.
  task automatic wait_idle();
    while (items_taken != items_queued || frame_reports.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // Input driver; also tracks the register and the receiver state.
  always @(posedge clk) begin : line_driver
    line_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      timeout_q = TIMEOUT_RESET;
      ph = PH_HUNT0;
      flen = '0;
      fsrc = '0;
      fdst = '0;
      count = '0;
      xsum = '0;
      elapsed = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) timeout_q = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        advance_receiver(in_ch.mode, in_ch.rx_byte);
        items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (line_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          it = line_items.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.mode    <= it.mode;
          in_ch.rx_byte <= it.rx_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_reports.size() == 0) begin
          $display("%0t: result beat with none expected, actual kind %0d data %02h last %0d",
                   $time, out_ch.kind, out_ch.data_byte, out_ch.last);
          failed = 1'b1;
        end else begin
          want = frame_reports.pop_front();
          field_check("kind", 8'(want.kind), 8'(out_ch.kind));
          field_check("data_byte", want.data_byte, out_ch.data_byte);
          field_check("byte_index", want.byte_index, out_ch.byte_index);
          field_check("frame_length", want.frame_length, out_ch.frame_length);
          field_check("source_addr", want.source_addr, out_ch.source_addr);
          field_check("dest_addr", want.dest_addr, out_ch.dest_addr);
          field_check("computed_check", want.computed_check, out_ch.computed_check);
          field_check("last", 8'(want.last), 8'(out_ch.last));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_BYTE;
    in_ch.rx_byte = 8'd0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    send_gap_pct   = 21;
    recv_stall_pct = 66;
    cur_timeout    = TIMEOUT_RESET;
    timeout_plan   = '{32'd1, 32'hFFFF_FFFF, 32'd3, 32'd12, 32'd2,
                       32'($urandom_range(4, 40))};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a tick while hunting, two broken preambles (the second ends
    // on 01, which must not restart the hunt), an empty frame with ticks
    // inside it, and a one-byte frame with a bad check byte.
    push_item(MODE_TICK, 8'hFF);
    push_item(MODE_BYTE, PRE0);
    push_item(MODE_BYTE, PRE1);
    push_item(MODE_BYTE, 8'h05);
    push_item(MODE_BYTE, PRE0);
    push_item(MODE_BYTE, PRE1);
    push_item(MODE_BYTE, PRE2);
    push_item(MODE_BYTE, PRE0);
    push_frame(0, 8'hFF, 8'h00, 1'b0, 40);
    push_frame(1, 8'h00, 8'hFF, 1'b1, 0);
    wait_idle();

    // Random phases, each under its own timeout setting.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_gap_pct   = 66;
        recv_stall_pct = 21;
      end else if (p == 4) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      cur_timeout = timeout_plan[p];
      write_timeout(cur_timeout);
      // A frame of the largest length once, while the timeout cannot expire.
      if (cur_timeout == 32'hFFFF_FFFF) push_frame(255, 8'h5A, 8'hA5, 1'b0, 0);
      random_traffic(PHASE_ITEMS);
      wait_idle();
    end

    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: preamble_frame_receiver_xor_check_top.f
rtl/pfrx_pkg.sv
rtl/pfrx_in_if.sv
rtl/pfrx_out_if.sv
rtl/pfrx_cfg_if.sv
rtl/pfrx_step.sv
rtl/preamble_frame_receiver_xor_check_top.sv
sim/preamble_frame_receiver_xor_check_top_tb.sv
